// ----- src/sliding_window_median_assert.svh -----
// assertion macros for the running median filter
// used by the top level only; no other dependencies
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

`ifndef SYNTHESIS
`define SWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWM_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) else $error(msg);
`else
`define SWM_ASSERT(label, clk, rst_n, prop, msg)
`define SWM_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg)
`endif

`endif

// ----- src/swm_pkg.sv -----
// shared types and defaults for the running median filter
// no dependencies
package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int WS_BITS         = 7;
    localparam logic [WS_BITS-1:0] WS_RESET = 7'd3;

    // broadcast control for the cell row
    typedef struct packed {
        logic load;
        logic clear;
    } swm_ctrl_t;

    // flags handed between neighboring cells
    typedef struct packed {
        logic valid;
        logic gt;
    } swm_flag_t;

endpackage

// ----- src/swm_cell.sv -----
// one sorted slot of the median filter: value, age and valid bit
// depends on swm_pkg
module swm_cell
    import swm_pkg::*;
#(
    parameter int DW       = SAMPLE_BITS_DEF,
    parameter int AW       = 6,
    parameter bit IS_FIRST = 1'b0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  swm_ctrl_t            ctrl,
    input  logic signed [DW-1:0] sample_in,
    input  logic                 shift_up,
    input  logic [AW-1:0]        age_last,
    input  logic signed [DW-1:0] up_val,
    input  logic [AW-1:0]        up_age,
    input  swm_flag_t            up_flag,
    input  logic signed [DW-1:0] lo_val,
    input  logic [AW-1:0]        lo_age,
    input  swm_flag_t            lo_flag,
    output logic signed [DW-1:0] val,
    output logic [AW-1:0]        age,
    output swm_flag_t            flag,
    output logic signed [DW-1:0] r_val,
    output logic [AW-1:0]        r_age,
    output swm_flag_t            r_flag,
    output logic                 match
);

    logic signed [DW-1:0] val_reg;
    logic signed [DW-1:0] val_next;
    logic [AW-1:0]        age_reg;
    logic [AW-1:0]        age_next;
    logic                 valid_reg;
    logic                 valid_next;

    always_comb
    begin
        flag.valid = valid_reg;
        flag.gt    = valid_reg && (val_reg > sample_in);

        // slot content once the evicted entry is squeezed out
        r_val        = shift_up ? up_val : val_reg;
        r_age        = shift_up ? up_age : age_reg;
        r_flag.valid = shift_up ? up_flag.valid : valid_reg;
        // gt here means empty or greater than the new sample
        r_flag.gt    = shift_up ? (!up_flag.valid || up_flag.gt) : (!valid_reg || flag.gt);

        match = valid_reg && (age_reg == age_last);

        if (r_flag.gt)
        begin
            if (lo_flag.gt)
            begin
                val_next = lo_val;
                age_next = lo_age + AW'(1);
            end
            else
            begin
                val_next = sample_in;
                age_next = '0;
            end
        end
        else
        begin
            val_next = r_val;
            age_next = r_age + AW'(1);
        end

        valid_next = IS_FIRST || lo_flag.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

// ----- src/swm_median.sv -----
// output stage: picks the two middle slots, adds them, holds the result
// no package dependencies
module swm_median
#(
    parameter int DW = 32,
    parameter int N  = 64,
    parameter int IW = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pend,
    input  logic signed [DW-1:0] vals [N],
    input  logic [IW-1:0]        hi_idx,
    input  logic [IW-1:0]        lo_idx,
    input  logic                 out_ready,
    output logic                 take,
    output logic                 out_valid,
    output logic signed [DW:0]   median_doubled
);

    logic [DW-1:0]      hi_or;
    logic [DW-1:0]      lo_or;
    logic [DW:0]        sum;
    logic               out_valid_reg;
    logic signed [DW:0] median_reg;

    always_comb
    begin
        hi_or = '0;
        lo_or = '0;
        for (int i = 0; i < N; i++)
        begin
            if (IW'(i) == hi_idx)
            begin
                hi_or = hi_or | vals[i];
            end
            if (IW'(i) == lo_idx)
            begin
                lo_or = lo_or | vals[i];
            end
        end
        sum  = {hi_or[DW-1], hi_or} + {lo_or[DW-1], lo_or};
        take = pend && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            median_reg <= sum;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = median_reg;

endmodule

// ----- src/sliding_window_median.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+-----------------------------
// input     | in_valid / in_ready       | sample
// output    | out_valid / out_ready     | median_doubled
// config    | window_size_we            | window_size
//
// one sample per cycle while in_ready is high: the sorted cell row inserts and evicts in the same edge
// an accepted median waits in the pending stage until the output register takes it
// the pending stage and output register part the two sides; out_ready low backs up
// into in_ready only once both hold a result
// reset and any window_size write empty the window; no new result until it refills
//
// top level of the running median filter
// depends on swm_pkg, swm_cell, swm_median and sliding_window_median_assert.svh
`include "sliding_window_median_assert.svh"

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          window_size_we,
    input  logic [WS_BITS-1:0]            window_size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS:0]   median_doubled
);

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [WS_BITS-1:0] ws_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [CNT_W-1:0]   fill_inc;
    logic               pend_reg;
    logic               pend_next;
    logic [31:0]        ws_wide;
    logic [CNT_W-1:0]   w_eff;
    logic [IDX_W-1:0]   w_last;
    logic [IDX_W-1:0]   hi_idx;
    logic [IDX_W-1:0]   lo_idx;
    logic               full;
    logic               emit;
    logic               in_fire;
    logic               take;
    swm_ctrl_t          ctrl;

    logic signed [SAMPLE_BITS-1:0] cell_val [MAX_WINDOW];
    logic [IDX_W-1:0]              cell_age [MAX_WINDOW];
    swm_flag_t                     cell_flag [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_val    [MAX_WINDOW];
    logic [IDX_W-1:0]              r_age    [MAX_WINDOW];
    swm_flag_t                     r_flag   [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] up_val   [MAX_WINDOW];
    logic [IDX_W-1:0]              up_age   [MAX_WINDOW];
    swm_flag_t                     up_flag  [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] lo_val   [MAX_WINDOW];
    logic [IDX_W-1:0]              lo_age   [MAX_WINDOW];
    swm_flag_t                     lo_flag  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]         match_vec;
    logic [MAX_WINDOW-1:0]         shift_vec;
    logic [MAX_WINDOW-1:0]         valid_vec;

    // effective window: zero acts as one, oversize clips to the store
    always_comb
    begin
        ws_wide = 32'(ws_reg);
        if (ws_wide == 32'd0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (ws_wide > 32'(MAX_WINDOW))
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = CNT_W'(ws_wide);
        end
        w_last = IDX_W'(w_eff - CNT_W'(1));
        hi_idx = IDX_W'(w_eff >> 1);
        lo_idx = w_eff[0] ? hi_idx : (hi_idx - IDX_W'(1));
    end

    always_comb
    begin
        full       = (fill_reg == w_eff);
        fill_inc   = fill_reg + CNT_W'(1);
        emit       = full || (fill_inc == w_eff);
        in_ready   = !pend_reg || take;
        in_fire    = in_valid && in_ready;
        ctrl.load  = in_fire;
        ctrl.clear = window_size_we;

        fill_next = fill_reg;
        if (in_fire && !full)
        begin
            fill_next = fill_inc;
        end

        pend_next = pend_reg;
        if (in_fire && emit)
        begin
            pend_next = 1'b1;
        end
        else if (take)
        begin
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg   <= WS_RESET;
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else if (window_size_we)
        begin
            ws_reg   <= window_size;
            fill_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            pend_reg <= pend_next;
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_WINDOW; j++)
        begin : g_cell
            localparam logic [MAX_WINDOW-1:0] PREFIX =
                {MAX_WINDOW{1'b1}} >> (MAX_WINDOW - 1 - j);

            // slots at or above the evicted one take their upper neighbor
            assign shift_vec[j] = full && (|(match_vec & PREFIX));
            assign valid_vec[j] = cell_flag[j].valid;

            if (j < MAX_WINDOW - 1)
            begin : g_up
                assign up_val[j]  = cell_val[j+1];
                assign up_age[j]  = cell_age[j+1];
                assign up_flag[j] = cell_flag[j+1];
            end
            else
            begin : g_top
                assign up_val[j]  = '0;
                assign up_age[j]  = '0;
                assign up_flag[j] = '0;
            end

            if (j > 0)
            begin : g_lo
                assign lo_val[j]  = r_val[j-1];
                assign lo_age[j]  = r_age[j-1];
                assign lo_flag[j] = r_flag[j-1];
            end
            else
            begin : g_bottom
                assign lo_val[j]  = '0;
                assign lo_age[j]  = '0;
                assign lo_flag[j] = '0;
            end

            swm_cell #(
                .DW       (SAMPLE_BITS),
                .AW       (IDX_W),
                .IS_FIRST (j == 0)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sample_in (sample),
                .shift_up  (shift_vec[j]),
                .age_last  (w_last),
                .up_val    (up_val[j]),
                .up_age    (up_age[j]),
                .up_flag   (up_flag[j]),
                .lo_val    (lo_val[j]),
                .lo_age    (lo_age[j]),
                .lo_flag   (lo_flag[j]),
                .val       (cell_val[j]),
                .age       (cell_age[j]),
                .flag      (cell_flag[j]),
                .r_val     (r_val[j]),
                .r_age     (r_age[j]),
                .r_flag    (r_flag[j]),
                .match     (match_vec[j])
            );
        end
    endgenerate

    swm_median #(
        .DW (SAMPLE_BITS),
        .N  (MAX_WINDOW),
        .IW (IDX_W)
    ) u_median (
        .clk            (clk),
        .rst_n          (rst_n),
        .pend           (pend_reg),
        .vals           (cell_val),
        .hi_idx         (hi_idx),
        .lo_idx         (lo_idx),
        .out_ready      (out_ready),
        .take           (take),
        .out_valid      (out_valid),
        .median_doubled (median_doubled)
    );

    `SWM_ASSERT(a_fill_bound, clk, rst_n, (fill_reg <= w_eff), "fill count above window")
    `SWM_ASSERT(a_fill_cells, clk, rst_n, ($countones(valid_vec) == fill_reg), "cell valids disagree with fill count")
    `SWM_ASSERT_NEXT(a_full_emits, clk, rst_n, (in_fire && full && !window_size_we), pend_reg, "full window transaction gave no result")
    `SWM_ASSERT(a_one_evict, clk, rst_n, (!full || $onehot0(match_vec)), "more than one oldest entry")

endmodule
